### rtl/core/ccsoc_pkg.sv
// Shared widths, constants and register indexes of the coulomb-counting gauge.
`default_nettype none
package ccsoc_pkg;

    localparam int CURRENT_BITS = 16;
    localparam int TIME_BITS    = 32;

    localparam int CHG_W      = 38;
    localparam int SOC_W      = 14;
    localparam int VOLT_W     = 13;
    localparam int CAP_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int AMT_W      = CURRENT_BITS + TIME_BITS;
    localparam int SOC_PROD_W = CHG_W + SOC_W;
    localparam int ACC_W      = (AMT_W > SOC_PROD_W) ? AMT_W : SOC_PROD_W;
    localparam int DVD_W      = SOC_PROD_W;
    localparam int MULQ_W     = (CURRENT_BITS > CAP_W) ? CURRENT_BITS : CAP_W;
    localparam int MCAND_W    = CHG_W;
    localparam int SUM_W      = ((AMT_W > CHG_W) ? AMT_W : CHG_W) + 1;
    localparam int MUL_CNT_W  = $clog2(MULQ_W);
    localparam int DIV_CNT_W  = $clog2(DVD_W);

    localparam logic [MCAND_W-1:0] MS_PER_HOUR = MCAND_W'(3600000);
    localparam logic [SOC_W-1:0]   SOC_SCALE   = SOC_W'(10000);

    localparam logic [CAP_W-1:0]  CAPACITY_RST = CAP_W'(2000);
    localparam logic [VOLT_W-1:0] FULL_V_RST   = VOLT_W'(4200);
    localparam logic [VOLT_W-1:0] EMPTY_V_RST  = VOLT_W'(3000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY = 2'd0,
        CFG_FULL_V   = 2'd1,
        CFG_EMPTY_V  = 2'd2
    } cfg_idx_t;

endpackage
`default_nettype wire

### rtl/core/ccsoc_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
`default_nettype none
module ccsoc_mul (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [ccsoc_pkg::MCAND_W-1:0] mcand,
    input  wire logic [ccsoc_pkg::MULQ_W-1:0]  mplier,
    output logic                               done,
    output logic [ccsoc_pkg::ACC_W-1:0]        product
);

    localparam logic [ccsoc_pkg::MUL_CNT_W-1:0] LAST =
        ccsoc_pkg::MUL_CNT_W'(ccsoc_pkg::MULQ_W - 1);

    logic                              busy_reg,  busy_next;
    logic                              done_reg,  done_next;
    logic [ccsoc_pkg::MUL_CNT_W-1:0]   cnt_reg,   cnt_next;
    logic [ccsoc_pkg::ACC_W-1:0]       acc_reg,   acc_next;
    logic [ccsoc_pkg::MULQ_W-1:0]      mq_reg,    mq_next;
    logic [ccsoc_pkg::MCAND_W-1:0]     md_reg,    md_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        mq_next   = mq_reg;
        md_next   = md_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            mq_next   = mplier;
            md_next   = mcand;
        end
        else if (busy_reg)
        begin
            // accumulate: acc = 2*acc + bit * mcand
            acc_next = {acc_reg[ccsoc_pkg::ACC_W-2:0], 1'b0}
                     + (mq_reg[ccsoc_pkg::MULQ_W-1] ? ccsoc_pkg::ACC_W'(md_reg) : '0);
            mq_next  = {mq_reg[ccsoc_pkg::MULQ_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mq_reg  <= mq_next;
        md_reg  <= md_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule
`default_nettype wire

### rtl/core/ccsoc_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module ccsoc_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [ccsoc_pkg::DVD_W-1:0] dividend,
    input  wire logic [ccsoc_pkg::CHG_W-1:0] divisor,
    output logic                             done,
    output logic [ccsoc_pkg::DVD_W-1:0]      quotient
);

    localparam logic [ccsoc_pkg::DIV_CNT_W-1:0] LAST =
        ccsoc_pkg::DIV_CNT_W'(ccsoc_pkg::DVD_W - 1);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [ccsoc_pkg::DIV_CNT_W-1:0]   cnt_reg,  cnt_next;
    logic [ccsoc_pkg::DVD_W-1:0]       q_reg,    q_next;
    logic [ccsoc_pkg::CHG_W-1:0]       rem_reg,  rem_next;
    logic [ccsoc_pkg::CHG_W-1:0]       dv_reg,   dv_next;
    logic [ccsoc_pkg::CHG_W:0]         trial;
    logic [ccsoc_pkg::CHG_W+1:0]       diff;
    logic                              fits;

    always_comb
    begin
        trial = {rem_reg, q_reg[ccsoc_pkg::DVD_W-1]};
        diff  = {1'b0, trial} - (ccsoc_pkg::CHG_W+2)'(dv_reg);
        fits  = ~diff[ccsoc_pkg::CHG_W+1];

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dv_next   = dv_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            rem_next  = '0;
            dv_next   = divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when the divisor fits
            rem_next = fits ? diff[ccsoc_pkg::CHG_W-1:0] : trial[ccsoc_pkg::CHG_W-1:0];
            q_next   = {q_reg[ccsoc_pkg::DVD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dv_reg  <= dv_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
`default_nettype wire

### rtl/core/coulomb_counter_soc_gauge_core.sv
// Top level of the coulomb-counting state-of-charge gauge.
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------------
//  in      | in_valid / in_stall    | kind, voltage_mv, batt_current, time_ms
//  out     | out_valid / out_stall  | soc_centi, charge_left, saturated
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  One request at a time: in_stall is high from acceptance until the result loads.
//  A serial multiply takes 16 steps, a serial divide 52. Zero capacity skips the
//  final multiply and divide. A stalled result holds in the output register while
//  the next request is taken. Reset clears charge, time and flags.
`default_nettype none
module coulomb_counter_soc_gauge_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic                                  kind,
    input  wire logic [ccsoc_pkg::VOLT_W-1:0]          voltage_mv,
    input  wire logic signed [ccsoc_pkg::CURRENT_BITS-1:0] batt_current,
    input  wire logic [ccsoc_pkg::TIME_BITS-1:0]       time_ms,

    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [ccsoc_pkg::SOC_W-1:0]                soc_centi,
    output logic [ccsoc_pkg::CHG_W-1:0]                charge_left,
    output logic                                       saturated,

    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [ccsoc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [ccsoc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_FULL  = 12'b0000_0000_0010,
        S_INIT  = 12'b0000_0000_0100,
        S_LIN   = 12'b0000_0000_1000,
        S_LDIV  = 12'b0000_0001_0000,
        S_AMT   = 12'b0000_0010_0000,
        S_UPD   = 12'b0000_0100_0000,
        S_CLAMP = 12'b0000_1000_0000,
        S_SOC   = 12'b0001_0000_0000,
        S_SOCM  = 12'b0010_0000_0000,
        S_SOCD  = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } state_t;

    localparam int CB = ccsoc_pkg::CURRENT_BITS;
    localparam int TB = ccsoc_pkg::TIME_BITS;

    state_t                              state_reg,   state_next;
    logic                                mul_go_reg,  mul_go_next;
    logic                                div_go_reg,  div_go_next;
    logic [ccsoc_pkg::CAP_W-1:0]         cap_reg,     cap_next;
    logic [ccsoc_pkg::VOLT_W-1:0]        fv_reg,      fv_next;
    logic [ccsoc_pkg::VOLT_W-1:0]        ev_reg,      ev_next;
    logic [ccsoc_pkg::CHG_W-1:0]         charge_reg,  charge_next;
    logic [TB-1:0]                       prev_reg,    prev_next;
    logic                                known_reg,   known_next;
    logic                                sat_reg,     sat_next;
    logic                                out_vld_reg, out_vld_next;

    logic                                kind_reg,    kind_next;
    logic [ccsoc_pkg::VOLT_W-1:0]        volt_reg,    volt_next;
    logic [CB-1:0]                       cur_reg,     cur_next;
    logic [TB-1:0]                       time_reg,    time_next;
    logic [ccsoc_pkg::CHG_W-1:0]         full_reg,    full_next;
    logic [ccsoc_pkg::SUM_W-1:0]         sum_reg,     sum_next;
    logic [ccsoc_pkg::SOC_W-1:0]         soc_reg,     soc_next;
    logic [ccsoc_pkg::SOC_W-1:0]         soc_out_reg, soc_out_next;
    logic [ccsoc_pkg::CHG_W-1:0]         chg_out_reg, chg_out_next;
    logic                                sat_out_reg, sat_out_next;

    logic                                in_take;
    logic                                out_free;
    logic [ccsoc_pkg::MCAND_W-1:0]       mul_mcand;
    logic [ccsoc_pkg::MULQ_W-1:0]        mul_mplier;
    logic                                mul_done;
    logic [ccsoc_pkg::ACC_W-1:0]         mul_prod;
    logic [ccsoc_pkg::DVD_W-1:0]         div_dvd;
    logic [ccsoc_pkg::CHG_W-1:0]         div_dvs;
    logic                                div_done;
    logic [ccsoc_pkg::DVD_W-1:0]         div_quot;

    logic                                cur_neg;
    logic [CB-1:0]                       cur_mag;
    logic [TB-1:0]                       dt;
    logic [ccsoc_pkg::VOLT_W-1:0]        volt_span;
    logic [ccsoc_pkg::VOLT_W-1:0]        volt_den;
    logic [ccsoc_pkg::SUM_W-1:0]         chg_ext;
    logic [ccsoc_pkg::SUM_W-1:0]         amt_ext;
    logic [ccsoc_pkg::SUM_W-1:0]         chg_add;
    logic [ccsoc_pkg::SUM_W-1:0]         chg_sub;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_vld_reg || !out_stall;
    assign cfg_ready = 1'b1;

    assign cur_neg   = cur_reg[CB-1];
    assign cur_mag   = cur_neg ? (CB'(0) - cur_reg) : cur_reg;
    assign dt        = time_reg - prev_reg;
    assign volt_span = volt_reg - ev_reg;
    assign volt_den  = fv_reg - ev_reg;
    assign chg_ext   = ccsoc_pkg::SUM_W'(charge_reg);
    assign amt_ext   = ccsoc_pkg::SUM_W'(mul_prod[ccsoc_pkg::AMT_W-1:0]);
    assign chg_add   = chg_ext + amt_ext;
    assign chg_sub   = chg_ext - amt_ext;

    // operand select for the shared serial units
    always_comb
    begin
        mul_mcand  = '0;
        mul_mplier = '0;
        div_dvd    = mul_prod[ccsoc_pkg::DVD_W-1:0];
        div_dvs    = full_reg;
        unique case (state_reg)
            S_FULL:
            begin
                mul_mcand  = ccsoc_pkg::MS_PER_HOUR;
                mul_mplier = ccsoc_pkg::MULQ_W'(cap_reg);
            end
            S_LIN:
            begin
                mul_mcand  = full_reg;
                mul_mplier = ccsoc_pkg::MULQ_W'(volt_span);
            end
            S_AMT:
            begin
                mul_mcand  = ccsoc_pkg::MCAND_W'(dt);
                mul_mplier = ccsoc_pkg::MULQ_W'(cur_mag);
            end
            S_SOCM:
            begin
                mul_mcand  = charge_reg;
                mul_mplier = ccsoc_pkg::MULQ_W'(ccsoc_pkg::SOC_SCALE);
            end
            S_LDIV:
            begin
                div_dvs = ccsoc_pkg::CHG_W'(volt_den);
            end
            default:
            begin
                mul_mcand  = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        mul_go_next  = 1'b0;
        div_go_next  = 1'b0;
        cap_next     = cap_reg;
        fv_next      = fv_reg;
        ev_next      = ev_reg;
        charge_next  = charge_reg;
        prev_next    = prev_reg;
        known_next   = known_reg;
        sat_next     = sat_reg;
        out_vld_next = out_vld_reg;
        kind_next    = kind_reg;
        volt_next    = volt_reg;
        cur_next     = cur_reg;
        time_next    = time_reg;
        full_next    = full_reg;
        sum_next     = sum_reg;
        soc_next     = soc_reg;
        soc_out_next = soc_out_reg;
        chg_out_next = chg_out_reg;
        sat_out_next = sat_out_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ccsoc_pkg::CFG_CAPACITY: cap_next = cfg_data;
                ccsoc_pkg::CFG_FULL_V:   fv_next  = cfg_data[ccsoc_pkg::VOLT_W-1:0];
                ccsoc_pkg::CFG_EMPTY_V:  ev_next  = cfg_data[ccsoc_pkg::VOLT_W-1:0];
                default:                 cap_next = cap_reg;
            endcase
        end

        if (out_vld_reg && !out_stall)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    kind_next   = kind;
                    volt_next   = voltage_mv;
                    cur_next    = batt_current;
                    time_next   = time_ms;
                    sat_next    = 1'b0;
                    mul_go_next = 1'b1;
                    state_next  = S_FULL;
                end
            end
            S_FULL:
            begin
                if (mul_done)
                begin
                    full_next = mul_prod[ccsoc_pkg::CHG_W-1:0];
                    if (!kind_reg)
                    begin
                        state_next = S_INIT;
                    end
                    else if (!known_reg)
                    begin
                        // first timestamp: record it only
                        prev_next  = time_reg;
                        known_next = 1'b1;
                        state_next = S_SOC;
                    end
                    else
                    begin
                        mul_go_next = 1'b1;
                        state_next  = S_AMT;
                    end
                end
            end
            S_INIT:
            begin
                prev_next  = time_reg;
                known_next = 1'b1;
                priority if (volt_reg >= fv_reg)
                begin
                    charge_next = full_reg;
                    state_next  = S_SOC;
                end
                else if (volt_reg <= ev_reg)
                begin
                    charge_next = '0;
                    state_next  = S_SOC;
                end
                else
                begin
                    mul_go_next = 1'b1;
                    state_next  = S_LIN;
                end
            end
            S_LIN:
            begin
                if (mul_done)
                begin
                    div_go_next = 1'b1;
                    state_next  = S_LDIV;
                end
            end
            S_LDIV:
            begin
                if (div_done)
                begin
                    charge_next = div_quot[ccsoc_pkg::CHG_W-1:0];
                    state_next  = S_SOC;
                end
            end
            S_AMT:
            begin
                if (mul_done)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                // discharge floors at empty, charge adds
                if (cur_neg)
                begin
                    sum_next = chg_add;
                end
                else if (chg_sub[ccsoc_pkg::SUM_W-1])
                begin
                    sum_next = '0;
                    sat_next = 1'b1;
                end
                else
                begin
                    sum_next = chg_sub;
                end
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                if (sum_reg > ccsoc_pkg::SUM_W'(full_reg))
                begin
                    charge_next = full_reg;
                    sat_next    = 1'b1;
                end
                else
                begin
                    charge_next = sum_reg[ccsoc_pkg::CHG_W-1:0];
                end
                prev_next  = time_reg;
                state_next = S_SOC;
            end
            S_SOC:
            begin
                if (full_reg == '0)
                begin
                    soc_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    mul_go_next = 1'b1;
                    state_next  = S_SOCM;
                end
            end
            S_SOCM:
            begin
                if (mul_done)
                begin
                    div_go_next = 1'b1;
                    state_next  = S_SOCD;
                end
            end
            S_SOCD:
            begin
                if (div_done)
                begin
                    if (div_quot > ccsoc_pkg::DVD_W'(ccsoc_pkg::SOC_SCALE))
                    begin
                        soc_next = ccsoc_pkg::SOC_SCALE;
                    end
                    else
                    begin
                        soc_next = div_quot[ccsoc_pkg::SOC_W-1:0];
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    soc_out_next = soc_reg;
                    chg_out_next = charge_reg;
                    sat_out_next = sat_reg;
                    out_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            mul_go_reg  <= 1'b0;
            div_go_reg  <= 1'b0;
            cap_reg     <= ccsoc_pkg::CAPACITY_RST;
            fv_reg      <= ccsoc_pkg::FULL_V_RST;
            ev_reg      <= ccsoc_pkg::EMPTY_V_RST;
            charge_reg  <= '0;
            prev_reg    <= '0;
            known_reg   <= 1'b0;
            sat_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mul_go_reg  <= mul_go_next;
            div_go_reg  <= div_go_next;
            cap_reg     <= cap_next;
            fv_reg      <= fv_next;
            ev_reg      <= ev_next;
            charge_reg  <= charge_next;
            prev_reg    <= prev_next;
            known_reg   <= known_next;
            sat_reg     <= sat_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        volt_reg    <= volt_next;
        cur_reg     <= cur_next;
        time_reg    <= time_next;
        full_reg    <= full_next;
        sum_reg     <= sum_next;
        soc_reg     <= soc_next;
        soc_out_reg <= soc_out_next;
        chg_out_reg <= chg_out_next;
        sat_out_reg <= sat_out_next;
    end

    ccsoc_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_go_reg),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .done    (mul_done),
        .product (mul_prod)
    );

    ccsoc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign out_valid   = out_vld_reg;
    assign soc_centi   = soc_out_reg;
    assign charge_left = chg_out_reg;
    assign saturated   = sat_out_reg;

endmodule
`default_nettype wire

### tb/sv/coulomb_counter_soc_gauge_core_tb.sv
// Testbench for the coulomb-counting gauge core: random and directed requests.
module coulomb_counter_soc_gauge_core_tb;

    localparam logic KIND_INIT   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct {
        logic                               kind;
        logic [ccsoc_pkg::VOLT_W-1:0]       volt;
        logic [ccsoc_pkg::CURRENT_BITS-1:0] cur;
        logic [ccsoc_pkg::TIME_BITS-1:0]    stamp;
    } request_t;

    typedef struct packed {
        logic [ccsoc_pkg::SOC_W-1:0] soc;
        logic [ccsoc_pkg::CHG_W-1:0] charge;
        logic                        sat;
    } reading_t;

    logic                                      clk = 1'b0;
    logic                                      rst_n = 1'b0;
    logic                                      in_valid = 1'b0;
    logic                                      in_stall;
    logic                                      kind = KIND_INIT;
    logic [ccsoc_pkg::VOLT_W-1:0]              voltage_mv = '0;
    logic signed [ccsoc_pkg::CURRENT_BITS-1:0] batt_current = '0;
    logic [ccsoc_pkg::TIME_BITS-1:0]           time_ms = '0;
    logic                                      out_valid;
    logic                                      out_stall = 1'b0;
    logic [ccsoc_pkg::SOC_W-1:0]               soc_centi;
    logic [ccsoc_pkg::CHG_W-1:0]               charge_left;
    logic                                      saturated;
    logic                                      cfg_valid = 1'b0;
    logic                                      cfg_ready;
    logic [ccsoc_pkg::CFG_IDX_W-1:0]           cfg_index = ccsoc_pkg::CFG_CAPACITY;
    logic [ccsoc_pkg::CFG_DATA_W-1:0]          cfg_data = '0;

    request_t pending_requests[$];
    reading_t expected_readings[$];
    int       errors = 0;
    int       in_gap = 0;
    int       out_gap = 0;
    bit       calm = 1'b0;
    logic [ccsoc_pkg::TIME_BITS-1:0] stamp_now = '0;

    logic [ccsoc_pkg::CAP_W-1:0]     gauge_cap = ccsoc_pkg::CAPACITY_RST;
    logic [ccsoc_pkg::VOLT_W-1:0]    gauge_full_v = ccsoc_pkg::FULL_V_RST;
    logic [ccsoc_pkg::VOLT_W-1:0]    gauge_empty_v = ccsoc_pkg::EMPTY_V_RST;
    logic [63:0]                     gauge_charge = '0;
    logic [ccsoc_pkg::TIME_BITS-1:0] gauge_prev_t = '0;
    logic                            gauge_time_known = 1'b0;

    coulomb_counter_soc_gauge_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .voltage_mv   (voltage_mv),
        .batt_current (batt_current),
        .time_ms      (time_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .soc_centi    (soc_centi),
        .charge_left  (charge_left),
        .saturated    (saturated),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic reading_t next_gauge_reading(logic k,
            logic [ccsoc_pkg::VOLT_W-1:0] v,
            logic [ccsoc_pkg::CURRENT_BITS-1:0] cur,
            logic [ccsoc_pkg::TIME_BITS-1:0] t);
        reading_t                        r;
        logic [63:0]                     full_chg;
        logic [63:0]                     mag;
        logic [63:0]                     amount;
        logic [63:0]                     nxt;
        logic [63:0]                     soc;
        logic [ccsoc_pkg::TIME_BITS-1:0] dt;
        full_chg = 64'(gauge_cap) * 64'(ccsoc_pkg::MS_PER_HOUR);
        r.sat = 1'b0;
        if (k == KIND_INIT)
        begin
            if (v >= gauge_full_v)
                gauge_charge = full_chg;
            else if (v <= gauge_empty_v)
                gauge_charge = '0;
            else
                gauge_charge = (full_chg * 64'(v - gauge_empty_v))
                               / 64'(gauge_full_v - gauge_empty_v);
            gauge_prev_t = t;
            gauge_time_known = 1'b1;
        end
        else if (!gauge_time_known)
        begin
            gauge_prev_t = t;
            gauge_time_known = 1'b1;
        end
        else
        begin
            dt = t - gauge_prev_t;
            mag = cur[ccsoc_pkg::CURRENT_BITS-1]
                  ? ((64'd1 << ccsoc_pkg::CURRENT_BITS) - 64'(cur)) : 64'(cur);
            amount = mag * 64'(dt);
            if (!cur[ccsoc_pkg::CURRENT_BITS-1])
            begin
                if (amount > gauge_charge)
                begin
                    nxt = '0;
                    r.sat = 1'b1;
                end
                else
                    nxt = gauge_charge - amount;
            end
            else
                nxt = gauge_charge + amount;
            if (nxt > full_chg)
            begin
                nxt = full_chg;
                r.sat = 1'b1;
            end
            gauge_charge = 64'(nxt[ccsoc_pkg::CHG_W-1:0]);
            gauge_prev_t = t;
        end
        if (full_chg == 0)
            soc = '0;
        else
        begin
            soc = (gauge_charge * 64'd10000) / full_chg;
            if (soc > 64'd10000)
                soc = 64'd10000;
        end
        r.soc = soc[ccsoc_pkg::SOC_W-1:0];
        r.charge = gauge_charge[ccsoc_pkg::CHG_W-1:0];
        return r;
    endfunction

    // Drive requests; predict each one as it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        request_t req;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                expected_readings.push_back(
                    next_gauge_reading(kind, voltage_mv, batt_current, time_ms));
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (!calm && pending_requests.size() > 0 && $urandom_range(0, 4) == 0)
                begin
                    in_gap = $urandom_range(0, 13);
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    req = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    kind <= req.kind;
                    voltage_mv <= req.volt;
                    batt_current <= req.cur;
                    time_ms <= req.stamp;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Check results against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_readings.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got soc %0d charge %0d sat %0d",
                             $time, soc_centi, charge_left, saturated);
                    errors++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (soc_centi !== want.soc)
                    begin
                        $display("%0t: soc_centi expected %0d, got %0d",
                                 $time, want.soc, soc_centi);
                        errors++;
                    end
                    if (charge_left !== want.charge)
                    begin
                        $display("%0t: charge_left expected %0d, got %0d",
                                 $time, want.charge, charge_left);
                        errors++;
                    end
                    if (saturated !== want.sat)
                    begin
                        $display("%0t: saturated expected %0d, got %0d",
                                 $time, want.sat, saturated);
                        errors++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_gap = $urandom_range(0, 13);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic add_request(logic k, logic [ccsoc_pkg::VOLT_W-1:0] v,
            logic [ccsoc_pkg::CURRENT_BITS-1:0] cur, logic [ccsoc_pkg::TIME_BITS-1:0] t);
        request_t r;
        r.kind = k;
        r.volt = v;
        r.cur = cur;
        r.stamp = t;
        stamp_now = t;
        pending_requests.push_back(r);
    endtask

    task automatic add_random_requests(int n);
        request_t                        r;
        int                              pick;
        logic [ccsoc_pkg::TIME_BITS-1:0] dt;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                dt = $urandom;
            else if (pick < 20)
                dt = $urandom_range(0, 1000000);
            else if (pick < 25)
                dt = '0;
            else
                dt = $urandom_range(1, 2000);
            stamp_now += dt;
            r.stamp = stamp_now;
            r.kind = ($urandom_range(0, 99) < 10) ? KIND_INIT : KIND_SAMPLE;
            if ($urandom_range(0, 2) == 0)
                r.volt = ccsoc_pkg::VOLT_W'($urandom_range(0, 8191));
            else
                r.volt = ccsoc_pkg::VOLT_W'($urandom_range(gauge_empty_v, gauge_full_v));
            pick = $urandom_range(0, 99);
            if (pick < 50)
                r.cur = ccsoc_pkg::CURRENT_BITS'($urandom_range(0, 4000) - 2000);
            else if (pick < 75)
                r.cur = ccsoc_pkg::CURRENT_BITS'($urandom);
            else
            begin
                r.cur = ccsoc_pkg::CURRENT_BITS'($urandom_range(16384, 32767));
                if ($urandom_range(0, 1) == 1)
                    r.cur = -r.cur;
            end
            pending_requests.push_back(r);
        end
    endtask

    task automatic write_reg(ccsoc_pkg::cfg_idx_t idx, logic [ccsoc_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            ccsoc_pkg::CFG_CAPACITY: gauge_cap = data;
            ccsoc_pkg::CFG_FULL_V:   gauge_full_v = data[ccsoc_pkg::VOLT_W-1:0];
            ccsoc_pkg::CFG_EMPTY_V:  gauge_empty_v = data[ccsoc_pkg::VOLT_W-1:0];
            default:                 ;
        endcase
    endtask

    task automatic set_gauge(logic [ccsoc_pkg::CFG_DATA_W-1:0] cap,
            logic [ccsoc_pkg::CFG_DATA_W-1:0] full_v,
            logic [ccsoc_pkg::CFG_DATA_W-1:0] empty_v);
        write_reg(ccsoc_pkg::CFG_CAPACITY, cap);
        write_reg(ccsoc_pkg::CFG_FULL_V, full_v);
        write_reg(ccsoc_pkg::CFG_EMPTY_V, empty_v);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_readings.size() != 0);
    endtask

    initial
    begin
        logic [ccsoc_pkg::CFG_DATA_W-1:0] empty_pick;
        logic [ccsoc_pkg::CFG_DATA_W-1:0] cap_pick;
        logic [ccsoc_pkg::CFG_DATA_W-1:0] full_pick;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_request(KIND_SAMPLE, 13'd0, 16'sd500, 32'd1000);
        add_request(KIND_SAMPLE, 13'd4000, 16'sd1000, 32'd2000);
        add_request(KIND_INIT, 13'd4200, 16'sd0, 32'd2000);
        add_request(KIND_INIT, 13'd8191, 16'hFFFF, 32'd2100);
        add_request(KIND_INIT, 13'd3000, 16'sd0, 32'd2200);
        add_request(KIND_INIT, 13'd0, 16'sd0, 32'd2300);
        add_request(KIND_INIT, 13'd3001, 16'sd0, 32'd2400);
        add_request(KIND_INIT, 13'd4199, 16'sd0, 32'd2500);
        add_request(KIND_SAMPLE, 13'h1FFF, 16'h8000, 32'd2501);
        add_request(KIND_SAMPLE, 13'd0, 16'sd32767, 32'd102501);
        add_request(KIND_SAMPLE, 13'd0, 16'sd0, 32'hFFFF_FF00);
        add_request(KIND_INIT, 13'd3600, 16'sd0, 32'hFFFF_FFFF);
        add_request(KIND_SAMPLE, 13'd0, 16'sd100, 32'h0000_0100);
        add_request(KIND_INIT, 13'd4200, 16'sd0, 32'd0);
        add_request(KIND_SAMPLE, 13'd0, 16'sd7200, 32'd1000000);
        add_request(KIND_SAMPLE, 13'd0, -16'sd7200, 32'd2000000);
        add_request(KIND_SAMPLE, 13'd0, -16'sd1, 32'd2000001);
        add_request(KIND_SAMPLE, 13'd0, 16'sd1, 32'd2000001);
        wait_drained();
        write_reg(ccsoc_pkg::CFG_CAPACITY, 16'd500);
        add_request(KIND_INIT, 13'd5000, 16'sd0, 32'd2000100);
        wait_drained();
        write_reg(ccsoc_pkg::CFG_CAPACITY, 16'd100);
        add_request(KIND_SAMPLE, 13'd0, 16'sd0, 32'd2000200);
        add_request(KIND_INIT, 13'd3000, 16'sd0, 32'd2000300);
        add_request(KIND_SAMPLE, 13'd0, 16'sd1, 32'd2000301);
        wait_drained();

        set_gauge(16'd1, 16'd5000, 16'd0);
        add_random_requests(100);
        wait_drained();
        set_gauge(16'd65535, 16'd4200, 16'd4199);
        add_random_requests(100);
        wait_drained();
        set_gauge(16'd3, 16'd1, 16'd4999);
        add_random_requests(60);
        wait_drained();
        set_gauge(16'd0, 16'hFFFF, 16'd0);
        add_random_requests(40);
        wait_drained();
        repeat (4)
        begin
            cap_pick = ($urandom_range(0, 1) == 0)
                       ? ccsoc_pkg::CFG_DATA_W'($urandom_range(1, 40))
                       : ccsoc_pkg::CFG_DATA_W'($urandom_range(1, 65535));
            empty_pick = ccsoc_pkg::CFG_DATA_W'($urandom_range(0, 4999));
            full_pick = ccsoc_pkg::CFG_DATA_W'($urandom_range(32'(empty_pick) + 1, 5000));
            set_gauge(cap_pick, full_pick, empty_pick);
            add_random_requests(70);
            wait_drained();
        end
        set_gauge(16'd2000, 16'd4200, 16'd3000);
        calm = 1'b1;
        add_random_requests(50);
        wait_drained();

        repeat (200) @(posedge clk);
        if (expected_readings.size() != 0)
        begin
            $display("%0t: %0d results expected, got none", $time, expected_readings.size());
            errors++;
        end
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
